>>> rtl/u64alu_pkg.sv
`default_nettype none

package u64alu_pkg;

    // 64-bit data word shared by the top level and the multiplier
    typedef logic [63:0] word_t;

    // operation selector codes
    localparam logic [3:0] FUNC_ADD = 4'd0;
    localparam logic [3:0] FUNC_SUB = 4'd1;
    localparam logic [3:0] FUNC_MUL = 4'd2;
    localparam logic [3:0] FUNC_DIV = 4'd3;
    localparam logic [3:0] FUNC_MOD = 4'd4;
    localparam logic [3:0] FUNC_NEG = 4'd5;
    localparam logic [3:0] FUNC_POW = 4'd6;
    localparam logic [3:0] FUNC_EQ  = 4'd7;
    localparam logic [3:0] FUNC_LT  = 4'd8;
    localparam logic [3:0] FUNC_LE  = 4'd9;

    // handshake between the sequencer and the multiplier
    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic done;
    } mul_stat_t;

endpackage

`default_nettype wire

>>> rtl/uint64_integer_alu_unit.sv
// div and mod produce one quotient bit per cycle;
// pow: for each exponent bit, the accumulator is multiplied if the bit is set, then the base is squared;
// the squaring after the top exponent bit is skipped
// throughput: one item at a time, busy drops as the result is registered, next item at done
// reset: rst_n clears the sequencer and the done strobe, data registers are not reset
// the result is on the ports for one cycle with done high; the receiver cannot stall
`default_nettype none

module uint64_integer_alu_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [3:0]        func,
    input  wire u64alu_pkg::word_t operand_a,
    input  wire u64alu_pkg::word_t operand_b,
    output logic                   done,
    output u64alu_pkg::word_t      result_value,
    output logic                   divide_by_zero
);
    import u64alu_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_EXEC      = 8'b0000_0010,
        ST_DIV       = 8'b0000_0100,
        ST_MUL_ISSUE = 8'b0000_1000,
        ST_MUL_WAIT  = 8'b0001_0000,
        ST_POW_STEP  = 8'b0010_0000,
        ST_POW_ACC   = 8'b0100_0000,
        ST_POW_SQ    = 8'b1000_0000
    } state_t;

    state_t      state_reg;
    state_t      state_next;

    // a_reg: operand a, power base, dividend shifting out / quotient shifting in
    // b_reg: operand b, divisor, exponent shifting right
    // acc_reg: power accumulator, multiplicand, partial remainder
    logic [3:0]  func_reg;
    logic [3:0]  func_next;
    word_t       a_reg;
    word_t       a_next;
    word_t       b_reg;
    word_t       b_next;
    word_t       acc_reg;
    word_t       acc_next;
    logic [5:0]  count_reg;
    logic [5:0]  count_next;

    word_t       result_reg;
    word_t       result_next;
    logic        dz_reg;
    logic        dz_next;
    logic        done_reg;
    logic        done_next;

    // shared add/subtract unit, 65-bit operands and a 66-bit result so the borrow is visible
    logic [64:0] add_x;
    logic [64:0] add_y;
    logic        add_sub;
    logic [65:0] add_res;
    logic        borrow;
    logic        is_zero;

    // multiplier interface
    mul_ctl_t    mul_ctl;
    mul_stat_t   mul_stat;
    logic        mul_use_acc;
    word_t       mul_x;
    word_t       mul_product;

    logic        accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign add_res = add_sub ? ({1'b0, add_x} - {1'b0, add_y})
                             : ({1'b0, add_x} + {1'b0, add_y});
    assign borrow  = add_res[65];
    assign is_zero = (add_res[63:0] == 64'd0);

    assign mul_x = mul_use_acc ? acc_reg : a_reg;

    u64alu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .x       (mul_x),
        .y       (a_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    // adder operand selection
    always_comb
    begin
        add_x   = {1'b0, a_reg};
        add_y   = {1'b0, b_reg};
        add_sub = 1'b1;
        if (state_reg == ST_DIV)
        begin
            // shift next dividend bit into the partial remainder, try the divisor
            add_x = {acc_reg, a_reg[63]};
        end
        else if (func_reg == FUNC_ADD)
        begin
            add_sub = 1'b0;
        end
        else if (func_reg == FUNC_NEG)
        begin
            add_x = 65'd0;
            add_y = {1'b0, a_reg};
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        result_next = result_reg;
        dz_next     = dz_reg;
        done_next   = 1'b0;
        mul_ctl     = '0;
        mul_use_acc = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    a_next     = operand_a;
                    b_next     = operand_b;
                    acc_next   = 64'd0;
                    count_next = 6'd0;
                    state_next = ST_EXEC;
                    if ((func == FUNC_DIV || func == FUNC_MOD) && operand_b != 64'd0)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (func == FUNC_MUL)
                    begin
                        // multiplicand in acc, multiplier in a
                        acc_next   = operand_a;
                        a_next     = operand_b;
                        state_next = ST_MUL_ISSUE;
                    end
                    else if (func == FUNC_POW && operand_b != 64'd0)
                    begin
                        acc_next   = 64'd1;
                        state_next = ST_POW_STEP;
                    end
                end
            end

            ST_EXEC:
            begin
                dz_next     = 1'b0;
                result_next = 64'd0;
                unique case (func_reg)
                    FUNC_ADD, FUNC_SUB, FUNC_NEG: result_next = add_res[63:0];
                    FUNC_DIV:
                    begin
                        // only reached with a zero divisor
                        result_next = '1;
                        dz_next     = 1'b1;
                    end
                    FUNC_MOD:
                    begin
                        result_next = a_reg;
                        dz_next     = 1'b1;
                    end
                    FUNC_POW: result_next = 64'd1;
                    FUNC_EQ:  result_next = {63'd0, is_zero};
                    FUNC_LT:  result_next = {63'd0, borrow};
                    FUNC_LE:  result_next = {63'd0, borrow || is_zero};
                    default:  result_next = 64'd0;
                endcase
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                a_next = {a_reg[62:0], !borrow};
                if (!borrow)
                begin
                    acc_next = add_res[63:0];
                end
                else
                begin
                    acc_next = {acc_reg[62:0], a_reg[63]};
                end
                count_next = count_reg + 6'd1;
                if (count_reg == 6'd63)
                begin
                    result_next = (func_reg == FUNC_DIV) ? a_next : acc_next;
                    dz_next     = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_MUL_ISSUE:
            begin
                mul_ctl.start = 1'b1;
                mul_use_acc   = 1'b1;
                state_next    = ST_MUL_WAIT;
            end

            ST_MUL_WAIT:
            begin
                if (mul_stat.done)
                begin
                    result_next = mul_product;
                    dz_next     = 1'b0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_POW_STEP:
            begin
                // exponent is nonzero here
                mul_ctl.start = 1'b1;
                if (b_reg[0])
                begin
                    mul_use_acc = 1'b1;
                    state_next  = ST_POW_ACC;
                end
                else
                begin
                    state_next = ST_POW_SQ;
                end
            end

            ST_POW_ACC:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_product;
                    if (b_reg[63:1] == 63'd0)
                    begin
                        // no higher exponent bits, skip the last squaring
                        result_next = mul_product;
                        dz_next     = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        mul_ctl.start = 1'b1;
                        state_next    = ST_POW_SQ;
                    end
                end
            end

            ST_POW_SQ:
            begin
                if (mul_stat.done)
                begin
                    a_next     = mul_product;
                    b_next     = {1'b0, b_reg[63:1]};
                    state_next = ST_POW_STEP;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        dz_reg     <= dz_next;
    end

    assign done           = done_reg;
    assign result_value   = result_reg;
    assign divide_by_zero = dz_reg;

endmodule

`default_nettype wire

>>> rtl/u64alu_mul.sv
`default_nettype none

module u64alu_mul (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire u64alu_pkg::mul_ctl_t ctl,
    input  wire u64alu_pkg::word_t    x,
    input  wire u64alu_pkg::word_t    y,
    output u64alu_pkg::mul_stat_t     stat,
    output u64alu_pkg::word_t         product
);
    import u64alu_pkg::*;

    // step codes of the partial product sequence, one-hot
    typedef enum logic [3:0] {
        STEP_LL  = 4'b0001,
        STEP_LH  = 4'b0010,
        STEP_HL  = 4'b0100,
        STEP_SUM = 4'b1000
    } step_t;

    word_t       x_reg;
    word_t       y_reg;
    word_t       prod_reg;
    word_t       prod_next;
    word_t       acc_reg;
    word_t       acc_next;
    step_t       step_reg;
    step_t       step_next;
    logic        run_reg;
    logic        run_next;
    logic [31:0] mul_lhs;
    logic [31:0] mul_rhs;
    word_t       shifted_prod;

    // 32x32 partial products, high half of the cross terms falls off mod 2^64
    assign mul_lhs      = (step_reg == STEP_HL) ? x_reg[63:32] : x_reg[31:0];
    assign mul_rhs      = (step_reg == STEP_LH) ? y_reg[63:32] : y_reg[31:0];
    assign shifted_prod = {prod_reg[31:0], 32'd0};

    assign product   = acc_reg + shifted_prod;
    assign stat.done = run_reg && (step_reg == STEP_SUM);

    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        if (run_reg)
        begin
            unique case (step_reg)
                STEP_LL:
                begin
                    prod_next = word_t'(mul_lhs) * word_t'(mul_rhs);
                    step_next = STEP_LH;
                end
                STEP_LH:
                begin
                    acc_next  = prod_reg;
                    prod_next = word_t'(mul_lhs) * word_t'(mul_rhs);
                    step_next = STEP_HL;
                end
                STEP_HL:
                begin
                    acc_next  = acc_reg + shifted_prod;
                    prod_next = word_t'(mul_lhs) * word_t'(mul_rhs);
                    step_next = STEP_SUM;
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end
        if (ctl.start)
        begin
            run_next  = 1'b1;
            step_next = STEP_LL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire
